@@ rtl/core/lsbx_pkg.sv @@
// Package: shared types and constants of the LSB extractor.
package lsbx_pkg;

  // Default header length of the image file in bytes.
  localparam int unsigned HeaderBytesDef = 54;
  // Header counter width, wide enough for any header length up to 63.
  localparam int unsigned HdrCntW = 6;

  // Field widths.
  localparam int unsigned MagicW = 16;
  localparam int unsigned LenW   = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitCntW = 5;

  // Configuration port.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] RegAddrMagic = 3'd0;

  // Token queue depth.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Result kinds.
  typedef enum logic [1:0] {
    KindExt  = 2'd0,
    KindData = 2'd1,
    KindErr  = 2'd2
  } lsbx_kind_e;

  // Parse phases after the header.
  typedef enum logic [2:0] {
    PhMagic  = 3'd0,
    PhExtLen = 3'd1,
    PhExt    = 3'd2,
    PhDLen   = 3'd3,
    PhData   = 3'd4,
    PhIdle   = 3'd5
  } lsbx_phase_e;

  // One payload bit handed from front to back.
  typedef struct packed {
    logic lsb;
    logic restart;
  } lsbx_tok_t;

endpackage

@@ rtl/core/lsbx_if.sv @@
// Interfaces: input word channel and result word channel.
interface lsbx_in_if;
  import lsbx_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] pixel_byte;
  logic             image_start;

  modport source (output valid, output pixel_byte, output image_start, input ready);
  modport sink   (input valid, input pixel_byte, input image_start, output ready);
endinterface

interface lsbx_out_if;
  import lsbx_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       result_kind;
  logic [ByteW-1:0] out_byte;
  logic             last_of_field;

  modport source (output valid, output result_kind, output out_byte, output last_of_field,
                  input ready);
  modport sink   (input valid, input result_kind, input out_byte, input last_of_field,
                  output ready);
endinterface

@@ rtl/core/lsbx_front.sv @@
// Front end: accepts image words, skips the header, forwards payload bits.
module lsbx_front
  import lsbx_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsbx_in_if.sink    in_s,
  input  logic       tok_full_i,
  output logic       tok_push_o,
  output lsbx_tok_t  tok_o
);

  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic               restart_q, restart_d;
  logic               accept;
  logic [HdrCntW-1:0] cnt_eff;
  logic               rst_eff;

  assign in_s.ready = !tok_full_i;
  assign accept     = in_s.valid && in_s.ready;

  // Apply an image start before classifying the word.
  assign cnt_eff = in_s.image_start ? '0 : hdr_cnt_q;
  assign rst_eff = in_s.image_start || restart_q;

  // Count header words, forward the rest as payload bits.
  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    restart_d  = restart_q;
    tok_push_o = 1'b0;
    tok_o.lsb     = in_s.pixel_byte[0];
    tok_o.restart = rst_eff;
    if (accept) begin
      restart_d = rst_eff;
      hdr_cnt_d = cnt_eff;
      if (cnt_eff < HdrCntW'(HEADER_BYTES)) begin
        hdr_cnt_d = cnt_eff + 1'b1;
      end else begin
        tok_push_o = 1'b1;
        restart_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      restart_q <= 1'b1;
    end else begin
      hdr_cnt_q <= hdr_cnt_d;
      restart_q <= restart_d;
    end
  end

endmodule

@@ rtl/core/lsbx_fifo.sv @@
// Short token queue between front and back end.
module lsbx_fifo
  import lsbx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lsbx_tok_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output lsbx_tok_t data_o
);

  lsbx_tok_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]    cnt_q;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store pushed tokens.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/lsbx_back.sv @@
// Back end: gathers payload bits into magic, lengths and bytes, emits results.
module lsbx_back
  import lsbx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [MagicW-1:0] magic_word_i,
  input  logic              tok_empty_i,
  input  lsbx_tok_t         tok_i,
  output logic              tok_pop_o,
  lsbx_out_if.source        out_m
);

  lsbx_phase_e        phase_q, phase_d, ph_eff;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d, bc_eff;
  logic [LenW-1:0]    shift_q, shift_d, sh_eff, sh_new;
  logic [LenW-1:0]    remain_q, remain_d, remain_dec;
  logic               out_valid_q, out_valid_d;
  lsbx_kind_e         kind_q, kind_d;
  logic [ByteW-1:0]   byte_q, byte_d;
  logic               last_q, last_d;
  logic               emit;

  assign tok_pop_o = !tok_empty_i && (!out_valid_q || out_m.ready);

  // Restart the parse on the first bit of a new image.
  assign ph_eff     = tok_i.restart ? PhMagic : phase_q;
  assign bc_eff     = tok_i.restart ? '0 : bit_cnt_q;
  assign sh_eff     = tok_i.restart ? '0 : shift_q;
  assign sh_new     = sh_eff | (LenW'(tok_i.lsb) << bc_eff);
  assign remain_dec = remain_q - 1'b1;

  // Phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhMagic;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result word.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  // Next phase and result.
  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    remain_d  = remain_q;
    emit      = 1'b0;
    kind_d    = KindErr;
    byte_d    = '0;
    last_d    = 1'b0;
    if (tok_pop_o) begin
      phase_d   = ph_eff;
      bit_cnt_d = bc_eff + 1'b1;
      shift_d   = sh_new;
      unique case (ph_eff)
        PhMagic: begin
          if (bc_eff == BitCntW'(MagicW - 1)) begin
            bit_cnt_d = '0;
            shift_d   = '0;
            if (sh_new[MagicW-1:0] != magic_word_i) begin
              phase_d = PhIdle;
              emit    = 1'b1;
            end else begin
              phase_d = PhExtLen;
            end
          end
        end
        PhExtLen, PhDLen: begin
          if (bc_eff == BitCntW'(LenW - 1)) begin
            bit_cnt_d = '0;
            shift_d   = '0;
            remain_d  = sh_new;
            if (ph_eff == PhExtLen) begin
              phase_d = (sh_new != '0) ? PhExt : PhDLen;
            end else begin
              phase_d = (sh_new != '0) ? PhData : PhIdle;
            end
          end
        end
        PhExt, PhData: begin
          if (bc_eff == BitCntW'(ByteW - 1)) begin
            bit_cnt_d = '0;
            shift_d   = '0;
            remain_d  = remain_dec;
            emit      = 1'b1;
            kind_d    = (ph_eff == PhExt) ? KindExt : KindData;
            byte_d    = sh_new[ByteW-1:0];
            last_d    = (remain_dec == '0);
            if (last_d) begin
              phase_d = (ph_eff == PhExt) ? PhDLen : PhIdle;
            end
          end
        end
        default: begin
          // Idle: drop bits until the next image.
          bit_cnt_d = bit_cnt_q;
          shift_d   = shift_q;
        end
      endcase
    end
    out_valid_d = (out_valid_q && !out_m.ready) || emit;
  end

  assign out_m.valid         = out_valid_q;
  assign out_m.result_kind   = kind_q;
  assign out_m.out_byte      = byte_q;
  assign out_m.last_of_field = last_q;

endmodule

@@ rtl/core/lsb_stego_stream_extractor_top.sv @@
// Top level: LSB extractor with APB register port, front end, token queue, back end.
// Throughput: one image word per cycle, sustained, under no output stall.
// A result word is registered: the image word that completes it is written into the token
// queue when accepted, and the back end pops it from there and loads its output register.
// Reset: asynchronous, active low; clears the magic register and starts a new image parse.
module lsb_stego_stream_extractor_top
  import lsbx_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsbx_in_if.sink             in_s,
  lsbx_out_if.source          out_m,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [MagicW-1:0] magic_q;
  logic              tok_push, tok_pop, tok_full, tok_empty;
  lsbx_tok_t         tok_in, tok_out;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == RegAddrMagic) ? ApbDataW'(magic_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
    end else if (psel && penable && pwrite && (paddr == RegAddrMagic)) begin
      magic_q <= pwdata[MagicW-1:0];
    end
  end

  lsbx_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_s),
    .tok_full_i (tok_full),
    .tok_push_o (tok_push),
    .tok_o      (tok_in)
  );

  lsbx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .empty_o (tok_empty),
    .data_o  (tok_out)
  );

  lsbx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .magic_word_i (magic_q),
    .tok_empty_i  (tok_empty),
    .tok_i        (tok_out),
    .tok_pop_o    (tok_pop),
    .out_m        (out_m)
  );

endmodule

@@ verif/lsbx_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker: decodes the image word stream on its own and compares every result word.
module lsbx_result_checker
  import lsbx_pkg::*;
#(
  parameter int unsigned HDR_BYTES = HeaderBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsbx_in_if                  in_mon,
  lsbx_out_if                 out_mon,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output int                  fail_cnt_o,
  output int                  pend_cnt_o,
  output int                  res_cnt_o
);

  typedef struct packed {
    lsbx_kind_e       kind;
    logic [ByteW-1:0] data;
    logic             last;
  } lsbx_res_t;

  // Bit counter targets; a 32-bit length completes when the 5-bit counter wraps to zero.
  localparam logic [BitCntW-1:0] LenBits   = BitCntW'(LenW);
  localparam logic [BitCntW-1:0] ByteBits  = BitCntW'(ByteW);
  localparam logic [BitCntW-1:0] MagicBits = BitCntW'(MagicW);

  // Decoder state, mirrored from the block.
  logic [MagicW-1:0]  magic_reg;
  logic               in_header;
  logic [HdrCntW-1:0] hdr_cnt;
  lsbx_phase_e        phase;
  logic [BitCntW-1:0] bit_cnt;
  logic [LenW-1:0]    shifter;
  logic [LenW-1:0]    remaining;
  logic [MagicW-1:0]  magic_acc;

  lsbx_res_t decoded_q[$];
  int        fails;
  int        seen;

  function automatic void restart_parse();
    in_header = 1'b1;
    hdr_cnt   = '0;
    phase     = PhMagic;
    bit_cnt   = '0;
    shifter   = '0;
    remaining = '0;
    magic_acc = '0;
  endfunction

  // Shift one payload bit in; report when the field width is complete.
  function automatic bit gather_bit(input logic b, input logic [BitCntW-1:0] width);
    shifter = shifter | (LenW'(b) << bit_cnt);
    bit_cnt = bit_cnt + 1'b1;
    if (bit_cnt == width) begin
      bit_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the decoder by one image word; return 1 when it yields a result word.
  function automatic bit extract_step(input logic [ByteW-1:0] pix, input logic start,
                                      output lsbx_res_t res);
    logic       b;
    lsbx_kind_e kind;
    b   = pix[0];
    res = '{kind: KindExt, data: '0, last: 1'b0};
    if (start) restart_parse();
    if (in_header) begin
      if (hdr_cnt < HDR_BYTES) begin
        hdr_cnt = hdr_cnt + 1'b1;
        if (hdr_cnt == HDR_BYTES) begin
          in_header = 1'b0;
          phase     = PhMagic;
        end
        return 1'b0;
      end
      in_header = 1'b0;
      phase     = PhMagic;
    end
    case (phase)
      PhMagic: begin
        magic_acc = magic_acc | (MagicW'(b) << bit_cnt[3:0]);
        bit_cnt   = bit_cnt + 1'b1;
        if (bit_cnt == MagicBits) begin
          bit_cnt = '0;
          if (magic_acc != magic_reg) begin
            phase = PhIdle;
            res   = '{kind: KindErr, data: '0, last: 1'b0};
            return 1'b1;
          end
          phase   = PhExtLen;
          shifter = '0;
        end
      end
      PhExtLen, PhDLen: begin
        if (gather_bit(b, LenBits)) begin
          remaining = shifter;
          shifter   = '0;
          if (phase == PhExtLen) phase = (remaining != '0) ? PhExt : PhDLen;
          else phase = (remaining != '0) ? PhData : PhIdle;
        end
      end
      PhExt, PhData: begin
        if (gather_bit(b, ByteBits)) begin
          kind      = (phase == PhExt) ? KindExt : KindData;
          res.kind  = kind;
          res.data  = shifter[ByteW-1:0];
          shifter   = '0;
          remaining = remaining - 1'b1;
          res.last  = (remaining == '0);
          if (res.last) phase = (phase == PhExt) ? PhDLen : PhIdle;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Compare result words first, then decode the accepted image word and track the magic register.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    lsbx_res_t want;
    lsbx_res_t fresh;
    if (!rst_ni) begin
      magic_reg = '0;
      restart_parse();
      decoded_q.delete();
      fails = 0;
      seen  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        if (decoded_q.size() == 0) begin
          $error("unexpected result word: result_kind %0d out_byte %02h last_of_field %0b",
                 out_mon.result_kind, out_mon.out_byte, out_mon.last_of_field);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          if (out_mon.result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_mon.result_kind);
            fails++;
          end
          if (out_mon.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_mon.out_byte);
            fails++;
          end
          if (out_mon.last_of_field !== want.last) begin
            $error("last_of_field: expected %0b, got %0b", want.last, out_mon.last_of_field);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (extract_step(in_mon.pixel_byte, in_mon.image_start, fresh)) begin
          decoded_q.push_back(fresh);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RegAddrMagic) begin
        magic_reg = pwdata_i[MagicW-1:0];
      end
    end
    fail_cnt_o <= fails;
    pend_cnt_o <= decoded_q.size();
    res_cnt_o  <= seen;
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, image stimulus, result stalls, watchdog and verdict.
module tb_top;
  import lsbx_pkg::*;

  localparam int ItemTarget   = 1900;
  localparam int ResultTarget = 30;
  localparam int HoldCycles   = 300;
  localparam int WatchLimit   = 2000;
  localparam int SettleCycles = 8;
  localparam int DrainCycles  = 20;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int fail_cnt;
  int pend_cnt;
  int res_cnt;

  lsbx_in_if  in_if ();
  lsbx_out_if out_if ();

  lsb_stego_stream_extractor_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (in_if),
    .out_m   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lsbx_result_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .fail_cnt_o (fail_cnt),
    .pend_cnt_o (pend_cnt),
    .res_cnt_o  (res_cnt)
  );

  // Clock: 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  logic [ByteW-1:0]  image_q[$];
  logic [MagicW-1:0] cur_magic;
  int burst_left;
  int words_sent;
  int results_est;
  int images_sent;
  int magic_writes;

  // Append payload bits, LSB first, each in the low bit of a random image byte.
  function automatic void push_bits(input logic [LenW-1:0] v, input int nbits);
    for (int k = 0; k < nbits; k++) image_q.push_back({7'($urandom), v[k]});
  endfunction

  function automatic int pick_len(input int max_len);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_len);
  endfunction

  // Offer one image word in bursts with random gaps; return once it is accepted.
  task automatic send_word(input logic [ByteW-1:0] pix, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel_byte  <= pix;
    in_if.image_start <= start;
    burst_left--;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  // Build one image, send it (cut short if asked), then trailing junk words.
  task automatic send_image(input bit fresh, input logic [MagicW-1:0] magic,
                            input logic [LenW-1:0] ext_len, input int ext_cnt,
                            input logic [LenW-1:0] data_len, input int data_cnt,
                            input int cut, input int trail);
    int n;
    image_q.delete();
    for (int i = 0; i < HeaderBytesDef; i++) begin
      image_q.push_back((i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom));
    end
    push_bits(magic, MagicW);
    push_bits(ext_len, LenW);
    repeat (ext_cnt) push_bits(LenW'($urandom_range(0, 255)), ByteW);
    push_bits(data_len, LenW);
    repeat (data_cnt) push_bits(LenW'($urandom_range(0, 255)), ByteW);
    n = (cut > 0 && cut < image_q.size()) ? cut : image_q.size();
    for (int i = 0; i < n; i++) send_word(image_q[i], fresh && (i == 0));
    repeat (trail) send_word(8'($urandom), 1'b0);
    images_sent++;
    if (magic == cur_magic) begin
      results_est += ext_cnt + data_cnt;
    end else begin
      results_est += 1;
    end
  endtask

  // Let the block drain, then write the magic register over the APB port.
  task automatic set_magic(input logic [MagicW-1:0] m);
    in_if.valid <= 1'b0;
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegAddrMagic;
    pwdata  <= {16'($urandom), m};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_magic = m;
    magic_writes++;
  endtask

  // Receiver: stall patterns that change over time, plus one long hold-off under load.
  initial begin
    int  mode;
    int  mode_left;
    int  period;
    int  low_len;
    int  ph;
    int  hold;
    bit  held;
    mode_left = 0;
    hold      = 0;
    held      = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && words_sent > 400 && pend_cnt > 0) begin
        held = 1'b1;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(40, 200);
          period    = $urandom_range(2, 7);
          low_len   = $urandom_range(1, period - 1);
          ph        = 0;
        end
        mode_left--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          default: begin
            out_if.ready <= (ph >= low_len);
            ph = (ph + 1) % period;
          end
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WatchLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [MagicW-1:0] m;
    logic [LenW-1:0]   el;
    logic [LenW-1:0]   dl;
    int                ec;
    int                dc;
    int                cut;
    burst_left   = 0;
    words_sent   = 0;
    results_est  = 0;
    images_sent  = 0;
    magic_writes = 0;
    cur_magic    = '0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.pixel_byte  <= '0;
    in_if.image_start <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first image without a start marker, zero-length fields, magic extremes,
    // mismatch with ignored tail, oversized lengths cut by a restart, restart inside a header.
    send_image(1'b0, 16'h0000, 1, 1, 1, 1, 0, 0);
    send_image(1'b1, 16'h0000, 0, 0, 2, 2, 0, 0);
    send_image(1'b1, 16'h0000, 2, 2, 0, 0, 0, 5);
    set_magic(16'hFFFF);
    send_image(1'b1, 16'hFFFF, 0, 0, 0, 0, 0, 3);
    send_image(1'b1, 16'hFFFE, 1, 1, 1, 1, 0, 6);
    send_image(1'b1, 16'h7FFF, 1, 1, 1, 1, 0, 0);
    send_image(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 2, 0, 0, 0, 0);
    send_image(1'b1, 16'hFFFF, 3, 3, 3, 3, 40, 0);
    send_image(1'b1, 16'hFFFF, 1, 1, 32'h8000_0000, 2, 0, 0);
    set_magic(16'h0000);
    send_image(1'b1, 16'h0000, 1, 1, 2, 2, 0, 2);

    // Random: a new magic per phase, then a few images, mostly well formed.
    while (words_sent < ItemTarget || results_est < ResultTarget) begin
      case ($urandom_range(0, 4))
        0:       set_magic(16'h0000);
        1:       set_magic(16'hFFFF);
        default: set_magic(16'($urandom));
      endcase
      repeat ($urandom_range(2, 4)) begin
        if (words_sent >= ItemTarget && results_est >= ResultTarget) break;
        m  = ($urandom_range(0, 9) != 0) ? cur_magic
                                         : cur_magic ^ (16'h1 << $urandom_range(0, 15));
        ec = pick_len(4);
        el = ec;
        if ($urandom_range(0, 19) == 0) begin
          el = $urandom;
          ec = 3;
        end
        dc = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : pick_len(6);
        dl = dc;
        if ($urandom_range(0, 19) == 0) begin
          dl = $urandom;
          dc = 3;
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 150) : 0;
        send_image(1'b1, m, el, ec, dl, dc, cut, $urandom_range(0, 3));
      end
    end

    // Drain: wait out every pending result word, then settle.
    in_if.valid <= 1'b0;
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d image words in %0d images under %0d magic settings;",
             words_sent, images_sent, magic_writes);
    $display("%0d results compared over zero lengths, magic mismatches, oversized lengths,",
             res_cnt);
    $display("cut images and a long output hold.");
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
